// ===== hw/rtl/vertical_four_tap_interpolator_top_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef VERTICAL_FOUR_TAP_INTERPOLATOR_TOP_DEFINES_SVH
`define VERTICAL_FOUR_TAP_INTERPOLATOR_TOP_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define VFTI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vfti check failed");

// Clocked check that also holds during reset.
`define VFTI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("vfti check failed");

`endif

// ===== hw/rtl/vfti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vfti_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned INNER_TAP  = 19;
  localparam int unsigned OUTER_TAP  = 3;
  localparam int unsigned ROUND_BIAS = 16;
  localparam int unsigned OUT_SHIFT  = 5;

  localparam logic [SAMPLE_W-1:0] NARROW_MASK   = 16'h00FF;
  localparam logic [SAMPLE_W-1:0] NARROW_MAX    = 16'h00FF;
  localparam logic [SAMPLE_W-1:0] MAX_LEVEL_RST = 16'h00FF;
  localparam logic [SAMPLE_W-1:0] MIN_LEVEL_RST = 16'h0000;
  localparam logic [7:0]          MASK_FLIP     = 8'h01;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_MODE = 2'd0,
    REG_MIN_LEVEL   = 2'd1,
    REG_MAX_LEVEL   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                sample_mode;
    logic [SAMPLE_W-1:0] min_level;
    logic [SAMPLE_W-1:0] max_level;
  } cfg_t;

  typedef struct packed {
    logic [15:0] row0_sample;
    logic [15:0] row2_sample;
    logic [15:0] row4_sample;
    logic [15:0] row6_sample;
    logic [7:0]  mask_byte;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic [15:0] mask_count;
    logic        last_out;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vfti_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vfti_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [vfti_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [vfti_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output vfti_pkg::cfg_t                         cfg_o
);

  vfti_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (vfti_pkg::cfg_idx_e'(cfg_idx_i))
        vfti_pkg::REG_SAMPLE_MODE: cfg_d.sample_mode = cfg_wdata_i[0];
        vfti_pkg::REG_MIN_LEVEL:   cfg_d.min_level   = cfg_wdata_i[15:0];
        vfti_pkg::REG_MAX_LEVEL:   cfg_d.max_level   = cfg_wdata_i[15:0];
        default:                   cfg_d = cfg_q; // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_mode <= 1'b0;
      cfg_q.min_level   <= vfti_pkg::MIN_LEVEL_RST;
      cfg_q.max_level   <= vfti_pkg::MAX_LEVEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vfti_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vfti_datapath (
  input  wire vfti_pkg::cfg_t                  cfg_i,
  input  wire vfti_pkg::in_t                   in_i,
  input  wire logic [vfti_pkg::COUNT_W-1:0]    count_i,
  output vfti_pkg::out_t                       res_o
);

  logic [15:0] smask;
  logic [15:0] r0, r2, r4, r6;
  logic [16:0] inner_sum, outer_sum;
  logic [21:0] pos, neg, diff, rounded;
  logic [16:0] scaled;
  logic [15:0] capped, upper, lower, pix;
  logic [16:0] cnt_sum;
  logic [15:0] cnt;

  always_comb begin
    // 8-bit mode looks at the low byte of each sample only
    smask = cfg_i.sample_mode ? 16'hFFFF : vfti_pkg::NARROW_MASK;
    r0 = in_i.row0_sample & smask;
    r2 = in_i.row2_sample & smask;
    r4 = in_i.row4_sample & smask;
    r6 = in_i.row6_sample & smask;

    inner_sum = {1'b0, r2} + {1'b0, r4};
    outer_sum = {1'b0, r0} + {1'b0, r6};
    pos = 22'(vfti_pkg::INNER_TAP) * {5'b0, inner_sum};
    neg = 22'(vfti_pkg::OUTER_TAP) * {5'b0, outer_sum};
    diff = (pos > neg) ? (pos - neg) : '0;
    rounded = diff + 22'(vfti_pkg::ROUND_BIAS);
    scaled = 17'(rounded >> vfti_pkg::OUT_SHIFT);

    capped = scaled[16] ? 16'hFFFF : scaled[15:0];
    upper = (capped > cfg_i.max_level) ? cfg_i.max_level : capped;
    // crossed bounds: the lower bound wins
    lower = (upper < cfg_i.min_level) ? cfg_i.min_level : upper;
    pix = (!cfg_i.sample_mode && (lower > vfti_pkg::NARROW_MAX)) ?
          vfti_pkg::NARROW_MAX : lower;

    cnt_sum = {1'b0, count_i} + {9'b0, in_i.mask_byte ^ vfti_pkg::MASK_FLIP};
    cnt = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];

    res_o.pixel_out  = pix;
    res_o.mask_count = cnt;
    res_o.last_out   = in_i.last_in;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vertical_four_tap_interpolator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake                | Payload
// --------+--------------------------+-------------------------
// in      | in_valid_i / in_stall_o  | in_data_i  (vfti_pkg::in_t)
// out     | out_valid_o / out_stall_i| out_data_o (vfti_pkg::out_t)
// cfg     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One pixel per clock sustained while out_stall_i stays low; a result passes the input
// register, then filter/clamp and the result register.
// The running mask count is the only loop: one saturating 16-bit add per pixel.
// Reset clears the pipeline valids, the count and the registers to their
// defaults. in_stall_o rises only while both stages are full and out_stall_i
// holds the result.

module vertical_four_tap_interpolator_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [vfti_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [vfti_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire vfti_pkg::in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output vfti_pkg::out_t                         out_data_o
);

  vfti_pkg::cfg_t cfg;
  vfti_pkg::in_t  s1_data_q;
  vfti_pkg::out_t res, out_data_q;
  logic           s1_valid_q, s1_valid_d;
  logic           out_valid_q, out_valid_d;
  logic [vfti_pkg::COUNT_W-1:0] count_q, count_d;
  logic           in_xfer, s2_load;

  vfti_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  vfti_datapath u_datapath (
    .cfg_i   (cfg),
    .in_i    (s1_data_q),
    .count_i (count_q),
    .res_o   (res)
  );

  always_comb begin
    // advance into the result register unless it holds a stalled result
    s2_load    = s1_valid_q && !(out_valid_q && out_stall_i);
    in_stall_o = s1_valid_q && !s2_load;
    in_xfer    = in_valid_i && !in_stall_o;

    s1_valid_d = in_xfer ? 1'b1 : (s2_load ? 1'b0 : s1_valid_q);

    if (s2_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    count_d = count_q;
    if (s2_load) begin
      count_d = s1_data_q.last_in ? '0 : res.mask_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
    if (s2_load) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vfti_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "vertical_four_tap_interpolator_top_defines.svh"

module vfti_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [vfti_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [vfti_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_stall_o,
  input  wire vfti_pkg::in_t                     in_data_i,
  input  wire logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  input  wire vfti_pkg::out_t                    out_data_o
);

  logic mode_q, mode_d;
  logic after_last_q, after_last_d;
  logic out_xfer;

  assign out_xfer = out_valid_o && !out_stall_i;

  always_comb begin
    mode_d = mode_q;
    if (cfg_we_i && (cfg_idx_i == vfti_pkg::REG_SAMPLE_MODE)) begin
      mode_d = cfg_wdata_i[0];
    end
    after_last_d = after_last_q;
    if (out_xfer) begin
      after_last_d = out_data_o.last_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      after_last_q <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      after_last_q <= after_last_d;
    end
  end

  // hold a stalled result
  `VFTI_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  // input backpressure comes only from a held result
  `VFTI_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i)
  // count restarts after the line closes
  `VFTI_ASSERT(a_count_restart, out_valid_o && after_last_q |-> out_data_o.mask_count <= 16'd255)
  // 8-bit mode saturates the pixel
  `VFTI_ASSERT(a_narrow_pixel, out_valid_o && !mode_q |-> out_data_o.pixel_out <= 16'd255)
  // no stall directly after reset is seen
  `VFTI_ASSERT_ALWAYS(a_reset_free, !rst_ni |=> !in_stall_o)

endmodule

bind vertical_four_tap_interpolator_top vfti_checker u_vfti_checker (.*);

`default_nettype wire

// ===== tb/vertical_four_tap_interpolator_top_test.sv =====
`timescale 1ns / 1ps

module vertical_four_tap_interpolator_top_test;

  // Index with no register behind it; writes there must change nothing.
  localparam logic [vfti_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int PHASE_ITEMS = 240;
  localparam int SAT_LINE_LEN = 300;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_e;

  typedef struct {
    bit                              is_cfg;
    logic [vfti_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [vfti_pkg::CFG_DATA_W-1:0] reg_val;
    vfti_pkg::in_t                   pix;
    bit                              typed;
    vfti_pkg::out_t                  want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [vfti_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [vfti_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  vfti_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  vfti_pkg::out_t out_data_o;

  // Shadow copy of the block: registers and the running mask count.
  logic        wide_mode = 1'b0;
  logic [15:0] floor_level = vfti_pkg::MIN_LEVEL_RST;
  logic [15:0] ceil_level = vfti_pkg::MAX_LEVEL_RST;
  logic [15:0] line_mask_count = '0;

  vfti_pkg::out_t pixels_due[$];
  plan_row_t plan[$];
  int failures = 0;
  int burst_left = 0;
  stall_style_e stall_style = STALL_NONE;
  int style_left = 0;
  int stall_tick = 0;

  vertical_four_tap_interpolator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Filter, clamp and count one pixel; advances the running count.
  function automatic vfti_pkg::out_t interpolate_pixel(input vfti_pkg::in_t it);
    vfti_pkg::out_t res;
    logic [15:0] smask;
    logic [31:0] r0, r2, r4, r6, pos, neg, acc;
    logic [16:0] cnt;
    smask = wide_mode ? 16'hFFFF : vfti_pkg::NARROW_MASK;
    r0 = 32'(it.row0_sample & smask);
    r2 = 32'(it.row2_sample & smask);
    r4 = 32'(it.row4_sample & smask);
    r6 = 32'(it.row6_sample & smask);
    pos = vfti_pkg::INNER_TAP * (r2 + r4);
    neg = vfti_pkg::OUTER_TAP * (r0 + r6);
    acc = (pos > neg) ? pos - neg : 32'd0;
    acc = (acc + vfti_pkg::ROUND_BIAS) >> vfti_pkg::OUT_SHIFT;
    if (acc > 32'h0000_FFFF) acc = 32'h0000_FFFF;
    if (acc > {16'd0, ceil_level}) acc = {16'd0, ceil_level};
    if (acc < {16'd0, floor_level}) acc = {16'd0, floor_level};
    if (!wide_mode && acc > {16'd0, vfti_pkg::NARROW_MAX}) acc = {16'd0, vfti_pkg::NARROW_MAX};
    cnt = {1'b0, line_mask_count} + {9'd0, it.mask_byte ^ vfti_pkg::MASK_FLIP};
    if (cnt[16]) cnt = 17'h0FFFF;
    res.pixel_out = acc[15:0];
    res.mask_count = cnt[15:0];
    res.last_out = it.last_in;
    line_mask_count = it.last_in ? 16'd0 : cnt[15:0];
    return res;
  endfunction

  function automatic plan_row_t item_row(input logic [15:0] r0, input logic [15:0] r2,
                                         input logic [15:0] r4, input logic [15:0] r6,
                                         input logic [7:0] mask, input logic last,
                                         input bit typed = 1'b0,
                                         input logic [15:0] px = '0,
                                         input logic [15:0] cnt = '0);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.pix = '{row0_sample: r0, row2_sample: r2, row4_sample: r4, row6_sample: r6,
                mask_byte: mask, last_in: last};
    row.typed = typed;
    row.want = '{pixel_out: px, mask_count: cnt, last_out: last};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [vfti_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [vfti_pkg::CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, pix: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic vfti_pkg::in_t random_pixel(input logic wide);
    vfti_pkg::in_t p;
    logic [15:0] base;
    logic [15:0] taps[4];
    int style;
    style = $urandom_range(0, 9);
    base = 16'($urandom);
    for (int i = 0; i < 4; i++) begin
      if (style < 4) begin
        taps[i] = 16'($urandom);
      end else if (style < 8) begin
        // Smooth column: taps close together so the clamps matter.
        if (wide) taps[i] = base ^ 16'($urandom_range(0, 255));
        else taps[i] = {8'($urandom), base[7:0] ^ 8'($urandom_range(0, 15))};
      end else begin
        case ($urandom_range(0, 3))
          0: taps[i] = 16'h0000;
          1: taps[i] = 16'h00FF;
          2: taps[i] = 16'hFFFF;
          default: taps[i] = 16'($urandom);
        endcase
      end
    end
    p.row0_sample = taps[0];
    p.row2_sample = taps[1];
    p.row4_sample = taps[2];
    p.row6_sample = taps[3];
    p.mask_byte = 8'($urandom);
    p.last_in = 1'b0;
    return p;
  endfunction

  // Drive one pixel, honoring the burst/gap pattern, and log its result at transfer.
  task automatic send_pixel(input vfti_pkg::in_t pix, input bit typed,
                            input vfti_pkg::out_t typed_val);
    vfti_pkg::out_t due;
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1: gap = 0;
        2: gap = $urandom_range(10, 24);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= pix;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    due = interpolate_pixel(pix);
    if (typed) due = typed_val;
    pixels_due.push_back(due);
  endtask

  // Write a register once the pipeline has drained.
  task automatic write_reg(input logic [vfti_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vfti_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      vfti_pkg::REG_SAMPLE_MODE: wide_mode = val[0];
      vfti_pkg::REG_MIN_LEVEL:   floor_level = val;
      vfti_pkg::REG_MAX_LEVEL:   ceil_level = val;
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (style_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      style_left = $urandom_range(16, 160);
    end else begin
      style_left--;
    end
    stall_tick++;
    case (stall_style)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall_i <= ((stall_tick % 5) < 2);
      default:        out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    vfti_pkg::out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected result transfer: %p", out_data_o);
        failures++;
      end else begin
        want = pixels_due.pop_front();
        if (out_data_o.pixel_out !== want.pixel_out) begin
          $error("pixel_out: expected %0d, got %0d", want.pixel_out, out_data_o.pixel_out);
          failures++;
        end
        if (out_data_o.mask_count !== want.mask_count) begin
          $error("mask_count: expected %0d, got %0d", want.mask_count, out_data_o.mask_count);
          failures++;
        end
        if (out_data_o.last_out !== want.last_out) begin
          $error("last_out: expected %0d, got %0d", want.last_out, out_data_o.last_out);
          failures++;
        end
      end
    end
  end

  initial begin
    vfti_pkg::in_t pix;
    int len;
    int sent;
    int drain;
    bit sat_line;
    logic mode;
    logic [15:0] lo, hi;

    // Reset defaults: 8-bit samples, levels 0..255.
    plan.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1, 0, 1));
    plan.push_back(item_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1, 255, 255));
    // Outer taps dominate: sum goes negative.
    plan.push_back(item_row(16'h00FF, 16'h0000, 16'h0000, 16'h00FF, 8'h01, 1'b1, 1, 0, 255));
    // High byte only: invisible in 8-bit mode.
    plan.push_back(item_row(16'h0000, 16'h0100, 16'h0100, 16'h0000, 8'h01, 1'b0, 1, 0, 0));
    plan.push_back(item_row(16'h0000, 16'd100, 16'd100, 16'h0000, 8'h00, 1'b1, 1, 119, 1));
    plan.push_back(item_row(16'h1234, 16'h00AB, 16'h5678, 16'h9ABC, 8'h55, 1'b1));
    plan.push_back(cfg_row(vfti_pkg::REG_SAMPLE_MODE, 16'h0001));
    plan.push_back(cfg_row(vfti_pkg::REG_MAX_LEVEL, 16'hFFFF));
    plan.push_back(item_row(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF, 1'b0, 1, 65535, 254));
    plan.push_back(item_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h01, 1'b0));
    plan.push_back(item_row(16'h0800, 16'h1000, 16'h1100, 16'h0900, 8'hA5, 1'b0));
    // Crossed bounds: the lower bound wins.
    plan.push_back(cfg_row(vfti_pkg::REG_MIN_LEVEL, 16'd1000));
    plan.push_back(cfg_row(vfti_pkg::REG_MAX_LEVEL, 16'd500));
    plan.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h01, 1'b1, 1, 1000, 418));
    plan.push_back(cfg_row(vfti_pkg::REG_SAMPLE_MODE, 16'h0000));
    plan.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1, 255, 1));
    plan.push_back(cfg_row(REG_UNUSED, 16'hFFFF));
    plan.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1, 255, 2));
    plan.push_back(cfg_row(vfti_pkg::REG_MIN_LEVEL, 16'h0000));
    plan.push_back(cfg_row(vfti_pkg::REG_MAX_LEVEL, 16'h0000));
    plan.push_back(item_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFE, 1'b0, 1, 0, 255));
    plan.push_back(cfg_row(vfti_pkg::REG_SAMPLE_MODE, 16'h0001));
    plan.push_back(cfg_row(vfti_pkg::REG_MIN_LEVEL, 16'hFFFF));
    plan.push_back(cfg_row(vfti_pkg::REG_MAX_LEVEL, 16'hFFFF));
    plan.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1, 65535, 256));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_pixel(plan[i].pix, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin mode = 1'b0; lo = 16'd0; hi = 16'd255; end
        1: begin mode = 1'b1; lo = 16'd0; hi = 16'hFFFF; end
        2: begin
          mode = 1'b1;
          lo = 16'($urandom_range(0, 30000));
          hi = 16'($urandom_range(lo, 65535));
        end
        3: begin
          mode = 1'b0;
          lo = 16'($urandom_range(0, 300));
          hi = 16'($urandom_range(0, 300));
        end
        4: begin
          mode = 1'b1;
          lo = 16'($urandom_range(20000, 65535));
          hi = 16'($urandom_range(0, 20000));
        end
        default: begin mode = 1'b0; lo = 16'd0; hi = 16'hFFFF; end
      endcase
      write_reg(vfti_pkg::REG_SAMPLE_MODE, {15'd0, mode});
      write_reg(vfti_pkg::REG_MIN_LEVEL, lo);
      write_reg(vfti_pkg::REG_MAX_LEVEL, hi);
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, 16'($urandom));

      // Open two phases with one long line of heavy masks to pin the count at its ceiling.
      sat_line = (ph == 1 || ph == 4);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sat_line) len = SAT_LINE_LEN;
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(40, 120);
        else len = $urandom_range(1, 24);
        for (int k = 0; k < len; k++) begin
          pix = random_pixel(wide_mode);
          if (sat_line) pix.mask_byte = $urandom_range(0, 1) ? 8'hFE : 8'hFF;
          pix.last_in = (k == len - 1);
          send_pixel(pix, 1'b0, '0);
        end
        sent += len;
        sat_line = 1'b0;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain = 0;
    while (pixels_due.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (pixels_due.size() != 0) begin
      $error("%0d results never arrived", pixels_due.size());
      failures++;
    end

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vfti_pkg.sv
hw/rtl/vfti_cfg_regs.sv
hw/rtl/vfti_datapath.sv
hw/rtl/vertical_four_tap_interpolator_top.sv
hw/rtl/vfti_checker.sv
tb/vertical_four_tap_interpolator_top_test.sv
